// File: design/bs3pt_pkg.sv
`default_nettype none
package bs3pt_pkg;

    localparam int SumW  = 30;
    localparam int SizeW = 21;
    localparam int AddrW = 4;
    localparam int DataW = 32;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [2:0] TERM_FIRST = 3'd0;
    localparam logic [2:0] TERM_LAST  = 3'd7;
    localparam logic [1:0] MUL_LAST   = 2'd3;
    localparam logic [1:0] SETTLE_CYC = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_READ,
        ST_DRAIN,
        ST_WRITE,
        ST_RESULT
    } t_state;

endpackage
`default_nettype wire

// File: design/box_sum_3d_prefix_table.sv
// Summed-volume table with box-sum queries.
// Input channel i_valid/o_stall carries one transaction per item: i_func low
// loads the next volume value (x outermost, z innermost), i_func high asks
// for the sum over a 1-based inclusive box. Loads give no result; each query
// gives one result on o_valid/i_stall (o_box_sum, o_bad_query).
// Items are handled one at a time around a single-port table memory with a
// registered read. A load keeps the input busy through seven neighbour
// reads, one drain and one write-back (a load with the table complete or
// sizes bad skips straight to write-back and stores nothing). A query runs
// four offset multiplies on one shared multiplier, eight reads, one drain
// and the output step, which waits while i_stall holds an earlier result.
// A flagged query result goes straight from acceptance to the output step.
// The output register lets the next item be accepted while a result waits;
// a second query result waits in the block while i_stall holds the first.
// Sizes are written through the APB port at byte addresses 0, 4 and 8; a
// write restarts loading and holds o_stall while the plane size and volume
// checks settle. Reset sets all sizes to 1, restarts loading, empties the
// output register and holds o_stall while the checks settle. The table
// itself is not cleared; every entry is written before it is read.
`default_nettype none
module box_sum_3d_prefix_table #(
    parameter int MAX_VOLUME = 1048576,
    parameter int VALUE_BITS = 10
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire                                  i_func,
    input  wire  [VALUE_BITS-1:0]                i_value,
    input  wire  [bs3pt_pkg::SizeW-1:0]          i_x_low,
    input  wire  [bs3pt_pkg::SizeW-1:0]          i_y_low,
    input  wire  [bs3pt_pkg::SizeW-1:0]          i_z_low,
    input  wire  [bs3pt_pkg::SizeW-1:0]          i_x_high,
    input  wire  [bs3pt_pkg::SizeW-1:0]          i_y_high,
    input  wire  [bs3pt_pkg::SizeW-1:0]          i_z_high,
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic [bs3pt_pkg::SumW-1:0]           o_box_sum,
    output logic                                 o_bad_query,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [bs3pt_pkg::AddrW-1:0]          paddr,
    input  wire  [bs3pt_pkg::DataW-1:0]          pwdata,
    output logic [bs3pt_pkg::DataW-1:0]          prdata,
    output logic                                 pready
);
    import bs3pt_pkg::*;

    localparam int AW    = $clog2(MAX_VOLUME);
    localparam int VW    = $clog2(MAX_VOLUME + 1);
    localparam int ProdW = SizeW + VW;
    localparam int ExtW  = SumW + VALUE_BITS;
    localparam int PlW   = 2 * SizeW;

    // configuration
    logic [SizeW-1:0] r_size_x, r_size_y, r_size_z;
    logic [PlW-1:0]   r_plane_full;
    logic [VW-1:0]    r_plane;
    logic             r_plane_big;
    logic [ProdW-1:0] r_vol;
    logic [1:0]       r_settle;
    logic             cfg_wr;
    logic             sizes_ok;

    // control
    t_state           r_state, n_state;
    logic [2:0]       r_term;
    logic [1:0]       r_step;
    logic             r_is_query;
    logic             r_ld_act;
    logic             r_bad;

    // load position
    logic [SizeW-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [AW-1:0]    r_load_idx;
    logic             r_complete;
    logic [SizeW-1:0] pos_z_inc, pos_y_inc, pos_x_inc;

    // query
    logic [SizeW-1:0] r_xl, r_yl, r_zl, r_xh, r_yh, r_zh;
    logic [AW-1:0]    r_ofs_xh, r_ofs_xl, r_ofs_yh, r_ofs_yl;
    logic [SizeW-1:0] mul_a;
    logic [VW-1:0]    mul_b;
    logic [ProdW-1:0] mul_p;

    // memory and accumulation
    logic [SumW-1:0]  mem [MAX_VOLUME];
    logic [SumW-1:0]  r_mem_q;
    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [AW-1:0]    ld_addr, q_addr;
    logic             term_live;
    logic             r_rd_act, r_rd_neg;
    logic [SumW-1:0]  r_acc;
    logic [ExtW-1:0]  value_ext;

    // handshakes
    logic             in_acc;
    logic             q_bad;
    logic             ld_ok;
    logic             out_free;
    logic             out_load;
    logic             r_out_valid;
    logic [SumW-1:0]  r_out_sum;
    logic             r_out_bad;

    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign o_stall  = (r_state != ST_IDLE) || (r_settle != '0);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_valid     = r_out_valid;
    assign o_box_sum   = r_out_sum;
    assign o_bad_query = r_out_bad;

    always_comb begin
        case (paddr[3:2])
            REG_SIZE_X: prdata = DataW'(r_size_x);
            REG_SIZE_Y: prdata = DataW'(r_size_y);
            REG_SIZE_Z: prdata = DataW'(r_size_z);
            default:    prdata = '0;
        endcase
    end

    // plane and volume checks, three register stages after a size change
    always_ff @(posedge i_clk) begin
        r_plane_full <= PlW'(r_size_y) * PlW'(r_size_z);
        r_plane_big  <= r_plane_full > PlW'(MAX_VOLUME);
        r_plane      <= (r_plane_full > PlW'(MAX_VOLUME)) ? VW'(MAX_VOLUME)
                                                           : VW'(r_plane_full);
        r_vol        <= ProdW'(r_size_x) * ProdW'(r_plane);
    end

    assign sizes_ok = (r_size_x != '0) && (r_size_y != '0) && (r_size_z != '0)
                   && !r_plane_big && (r_vol <= ProdW'(MAX_VOLUME));

    assign ld_ok = !r_complete && sizes_ok;
    assign q_bad = !r_complete || !sizes_ok
                || (i_x_low == '0) || (i_y_low == '0) || (i_z_low == '0)
                || (i_x_high > r_size_x) || (i_y_high > r_size_y)
                || (i_z_high > r_size_z)
                || (i_x_low > i_x_high) || (i_y_low > i_y_high)
                || (i_z_low > i_z_high);

    assign value_ext = ExtW'(i_value);

    assign pos_z_inc = r_pos_z + 1'b1;
    assign pos_y_inc = r_pos_y + 1'b1;
    assign pos_x_inc = r_pos_x + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_func == FUNC_QUERY) begin
                        n_state = q_bad ? ST_RESULT : ST_MUL;
                    end else begin
                        n_state = ld_ok ? ST_READ : ST_WRITE;
                    end
                end
            end
            ST_MUL: begin
                if (r_step == MUL_LAST) n_state = ST_READ;
            end
            ST_READ: begin
                if (r_term == TERM_LAST) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = r_is_query ? ST_RESULT : ST_WRITE;
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            ST_RESULT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    assign ld_addr = r_load_idx
                   - (r_term[0] ? AW'(r_plane)  : AW'(0))
                   - (r_term[1] ? AW'(r_size_z) : AW'(0))
                   - (r_term[2] ? AW'(1)        : AW'(0));
    assign q_addr  = (r_term[0] ? r_ofs_xl : r_ofs_xh)
                   + (r_term[1] ? r_ofs_yl : r_ofs_yh)
                   + (r_term[2] ? AW'(r_zl - SizeW'(2)) : AW'(r_zh - SizeW'(1)));

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_is_query ? q_addr : ld_addr;
        term_live = 1'b0;
        out_load  = 1'b0;
        mul_a     = r_xh - SizeW'(1);
        mul_b     = r_plane;
        case (r_state)
            ST_MUL: begin
                case (r_step)
                    2'd0: begin
                        mul_a = r_xh - SizeW'(1);
                        mul_b = r_plane;
                    end
                    2'd1: begin
                        mul_a = r_xl - SizeW'(2);
                        mul_b = r_plane;
                    end
                    2'd2: begin
                        mul_a = r_yh - SizeW'(1);
                        mul_b = VW'(r_size_z);
                    end
                    default: begin
                        mul_a = r_yl - SizeW'(2);
                        mul_b = VW'(r_size_z);
                    end
                endcase
            end
            ST_READ: begin
                if (r_is_query) begin
                    term_live = (!r_term[0] || r_xl != SizeW'(1))
                             && (!r_term[1] || r_yl != SizeW'(1))
                             && (!r_term[2] || r_zl != SizeW'(1));
                end else begin
                    term_live = (!r_term[0] || r_pos_x != '0)
                             && (!r_term[1] || r_pos_y != '0)
                             && (!r_term[2] || r_pos_z != '0);
                end
            end
            ST_WRITE: begin
                mem_we   = r_ld_act;
                mem_addr = r_load_idx;
            end
            ST_RESULT: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= r_acc;
        r_mem_q <= mem[mem_addr];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc) begin
            r_xl <= i_x_low;
            r_yl <= i_y_low;
            r_zl <= i_z_low;
            r_xh <= i_x_high;
            r_yh <= i_y_high;
            r_zh <= i_z_high;
            r_acc <= (i_func == FUNC_QUERY) ? '0 : value_ext[SumW-1:0];
        end else if (r_rd_act) begin
            r_acc <= r_rd_neg ? r_acc - r_mem_q : r_acc + r_mem_q;
        end
        if (r_state == ST_MUL) begin
            case (r_step)
                2'd0:    r_ofs_xh <= AW'(mul_p);
                2'd1:    r_ofs_xl <= AW'(mul_p);
                2'd2:    r_ofs_yh <= AW'(mul_p);
                default: r_ofs_yl <= AW'(mul_p);
            endcase
        end
        r_rd_neg <= r_is_query ? ^r_term : ~^r_term;
        if (out_load) begin
            r_out_sum <= r_bad ? '0 : r_acc;
            r_out_bad <= r_bad;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size_x    <= SizeW'(1);
            r_size_y    <= SizeW'(1);
            r_size_z    <= SizeW'(1);
            r_settle    <= SETTLE_CYC;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pos_z     <= '0;
            r_load_idx  <= '0;
            r_complete  <= 1'b0;
            r_term      <= TERM_FIRST;
            r_step      <= '0;
            r_is_query  <= 1'b0;
            r_ld_act    <= 1'b0;
            r_bad       <= 1'b0;
            r_rd_act    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_act <= term_live;

            if (r_settle != '0) r_settle <= r_settle - 1'b1;

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == ST_IDLE && in_acc) begin
                r_is_query <= (i_func == FUNC_QUERY);
                r_ld_act   <= (i_func == FUNC_LOAD) && ld_ok;
                r_bad      <= (i_func == FUNC_QUERY) && q_bad;
                r_term     <= (i_func == FUNC_QUERY) ? TERM_FIRST : TERM_FIRST + 3'd1;
                r_step     <= '0;
            end
            if (r_state == ST_MUL) r_step <= r_step + 1'b1;
            if (r_state == ST_READ) r_term <= r_term + 1'b1;

            if (r_state == ST_WRITE && r_ld_act) begin
                r_load_idx <= r_load_idx + 1'b1;
                if (pos_z_inc == r_size_z) begin
                    r_pos_z <= '0;
                    if (pos_y_inc == r_size_y) begin
                        r_pos_y <= '0;
                        if (pos_x_inc == r_size_x) begin
                            r_pos_x    <= '0;
                            r_complete <= 1'b1;
                        end else begin
                            r_pos_x <= pos_x_inc;
                        end
                    end else begin
                        r_pos_y <= pos_y_inc;
                    end
                end else begin
                    r_pos_z <= pos_z_inc;
                end
            end

            if (cfg_wr && (paddr[3:2] inside {REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z})) begin
                case (paddr[3:2])
                    REG_SIZE_X: r_size_x <= pwdata[SizeW-1:0];
                    REG_SIZE_Y: r_size_y <= pwdata[SizeW-1:0];
                    REG_SIZE_Z: r_size_z <= pwdata[SizeW-1:0];
                    default:    ;
                endcase
                r_settle   <= SETTLE_CYC;
                r_pos_x    <= '0;
                r_pos_y    <= '0;
                r_pos_z    <= '0;
                r_load_idx <= '0;
                r_complete <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// File: design/bs3pt_checker.sv
`default_nettype none
module bs3pt_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_valid,
    input wire                          o_stall,
    input wire                          o_valid,
    input wire                          i_stall,
    input wire [bs3pt_pkg::SumW-1:0]    o_box_sum,
    input wire                          o_bad_query,
    input wire                          psel,
    input wire                          penable,
    input wire                          pwrite,
    input wire [bs3pt_pkg::AddrW-1:0]   paddr
);
    import bs3pt_pkg::*;

    // flagged query carries no sum
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_query |-> o_box_sum == '0)
        else $error("flagged result with nonzero sum");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not held off after a transaction");

    // size write holds the input off while checks settle
    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite
        && (paddr[3:2] == REG_SIZE_X || paddr[3:2] == REG_SIZE_Y
            || paddr[3:2] == REG_SIZE_Z) |=> o_stall)
        else $error("input open straight after size write");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_box_sum) && $stable(o_bad_query))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

endmodule

bind box_sum_3d_prefix_table bs3pt_checker u_bs3pt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_box_sum   (o_box_sum),
    .o_bad_query (o_bad_query),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr)
);
`default_nettype wire
